// File: rtl/core/owbm_pkg.sv
// Shared types and constants for the 1-Wire bus master core.
// Holds register reset values, register indexes, opcode codes and the result layout.
// No dependencies.
package owbm_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_RESET_LOW     = 3'd0;
	localparam logic [2:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [2:0] REG_RESET_RECOVER = 3'd2;
	localparam logic [2:0] REG_WR1_LOW       = 3'd3;
	localparam logic [2:0] REG_WR1_RELEASE   = 3'd4;
	localparam logic [2:0] REG_WR0_LOW       = 3'd5;
	localparam logic [2:0] REG_RD_SAMPLE     = 3'd6;
	localparam logic [2:0] REG_RD_TAIL       = 3'd7;

	// register reset values
	localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
	localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd85;
	localparam logic [9:0] RESET_RECOVER_DEF = 10'd395;
	localparam logic [7:0] WR1_LOW_DEF       = 8'd14;
	localparam logic [7:0] WR1_RELEASE_DEF   = 8'd46;
	localparam logic [7:0] WR0_LOW_DEF       = 8'd60;
	localparam logic [7:0] RD_SAMPLE_DEF     = 8'd13;
	localparam logic [7:0] RD_TAIL_DEF       = 8'd47;

	// command opcodes
	localparam logic [1:0] OP_NONE  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// one result item, fields from the highest bit down as packed in m_tdata
	typedef struct packed {
		logic [7:0] read_data;
		logic       presence;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} result_t;

endpackage

// File: rtl/core/one_wire_bus_master_core.sv
// 1-Wire bus master core: one input request per microsecond tick, one result per tick.
// A result appears in the output register in the cycle after its tick is accepted.
// One tick per cycle unless m_tready stalls; phase and timing counter update in one pass.
// Reset (arst_n, asynchronous): phase idle, counters and data cleared, timing registers
// return to their defaults (480, 85, 395, 14, 46, 60, 13, 47 ticks).
// Depends on owbm_pkg.
module one_wire_bus_master_core (
	input  logic        clk,
	input  logic        arst_n,
	// input ticks
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [7:0] write_data, [8] line_in, [15:9] zero
	input  logic [1:0]  s_tuser,   // [1:0] opcode
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] drive_low, [1] busy_res, [2] done_res,
	                               // [3] presence, [11:4] read_data, [15:12] zero
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_REC  = 4'd3;
	localparam logic [3:0] PH_WR_LOW   = 4'd4;
	localparam logic [3:0] PH_WR_REL   = 4'd5;
	localparam logic [3:0] PH_RD_LOW   = 4'd6;
	localparam logic [3:0] PH_RD_WAIT  = 4'd7;
	localparam logic [3:0] PH_RD_TAIL  = 4'd8;

	logic [9:0] reset_low_q, reset_recover_q;
	logic [7:0] presence_wait_q, wr1_low_q, wr1_release_q, wr0_low_q, rd_sample_q, rd_tail_q;

	logic [3:0] phase_q, phase_d, phase_w;
	logic [9:0] count_q, count_d, count_inc, len;
	logic [2:0] bit_q, bit_d;
	logic [7:0] shift_q, shift_d, shift_w;
	logic       presence_q, presence_d;
	logic [1:0] op_q, op_d;
	logic [7:0] rdres_q, rdres_d;
	logic       drive, busy, done, last;

	logic [1:0] opcode;
	logic [7:0] wdata;
	logic       line;
	logic       accept;

	owbm_pkg::result_t res_d, res_q;
	logic              out_valid_q;

	assign opcode = s_tuser;
	assign wdata  = s_tdata[7:0];
	assign line   = s_tdata[8];

	assign s_tready  = !out_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_low_q     <= owbm_pkg::RESET_LOW_DEF;
			presence_wait_q <= owbm_pkg::PRESENCE_WAIT_DEF;
			reset_recover_q <= owbm_pkg::RESET_RECOVER_DEF;
			wr1_low_q       <= owbm_pkg::WR1_LOW_DEF;
			wr1_release_q   <= owbm_pkg::WR1_RELEASE_DEF;
			wr0_low_q       <= owbm_pkg::WR0_LOW_DEF;
			rd_sample_q     <= owbm_pkg::RD_SAMPLE_DEF;
			rd_tail_q       <= owbm_pkg::RD_TAIL_DEF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				owbm_pkg::REG_RESET_LOW:     reset_low_q     <= cfg_data;
				owbm_pkg::REG_PRESENCE_WAIT: presence_wait_q <= cfg_data[7:0];
				owbm_pkg::REG_RESET_RECOVER: reset_recover_q <= cfg_data;
				owbm_pkg::REG_WR1_LOW:       wr1_low_q       <= cfg_data[7:0];
				owbm_pkg::REG_WR1_RELEASE:   wr1_release_q   <= cfg_data[7:0];
				owbm_pkg::REG_WR0_LOW:       wr0_low_q       <= cfg_data[7:0];
				owbm_pkg::REG_RD_SAMPLE:     rd_sample_q     <= cfg_data[7:0];
				owbm_pkg::REG_RD_TAIL:       rd_tail_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		// start a command only from idle; later opcodes are dropped
		phase_w = phase_q;
		shift_w = shift_q;
		op_d    = op_q;
		bit_d   = bit_q;
		count_d = count_q;
		if (phase_q == PH_IDLE && opcode != owbm_pkg::OP_NONE) begin
			op_d    = opcode;
			bit_d   = 3'd0;
			count_d = 10'd0;
			unique case (opcode)
				owbm_pkg::OP_RESET: phase_w = PH_RST_LOW;
				owbm_pkg::OP_WRITE: begin
					shift_w = wdata;
					phase_w = PH_WR_LOW;
				end
				default: begin
					shift_w = 8'd0;
					phase_w = PH_RD_LOW;
				end
			endcase
		end

		unique case (phase_w)
			PH_RST_LOW:  len = reset_low_q;
			PH_RST_WAIT: len = {2'd0, presence_wait_q};
			PH_RST_REC:  len = reset_recover_q;
			PH_WR_LOW:   len = {2'd0, shift_w[0] ? wr1_low_q : wr0_low_q};
			PH_WR_REL:   len = shift_w[0] ? {2'd0, wr1_release_q} : 10'd1;
			PH_RD_WAIT:  len = {2'd0, rd_sample_q};
			PH_RD_TAIL:  len = {2'd0, rd_tail_q};
			default:     len = 10'd1;
		endcase

		count_inc  = count_d + 10'd1;
		last       = (count_inc >= len);
		busy       = (phase_w != PH_IDLE);
		drive      = (phase_w == PH_RST_LOW) || (phase_w == PH_WR_LOW) || (phase_w == PH_RD_LOW);
		done       = 1'b0;
		phase_d    = phase_w;
		shift_d    = shift_w;
		presence_d = presence_q;
		rdres_d    = rdres_q;

		if (busy) begin
			count_d = last ? 10'd0 : count_inc;
			if (last) begin
				unique case (phase_w)
					PH_RST_LOW:  phase_d = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_d = !line;
						phase_d    = PH_RST_REC;
					end
					PH_RST_REC: begin
						done    = 1'b1;
						phase_d = PH_IDLE;
					end
					PH_WR_LOW:   phase_d = PH_WR_REL;
					PH_WR_REL: begin
						shift_d = {1'b0, shift_w[7:1]};
						if (bit_d == 3'd7) begin
							bit_d   = 3'd0;
							done    = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							bit_d   = bit_d + 3'd1;
							phase_d = PH_WR_LOW;
						end
					end
					PH_RD_LOW:   phase_d = PH_RD_WAIT;
					PH_RD_WAIT: begin
						// first bit read ends up in bit 0 after eight shifts
						shift_d = {line, shift_w[7:1]};
						phase_d = PH_RD_TAIL;
					end
					PH_RD_TAIL: begin
						if (bit_d == 3'd7) begin
							bit_d   = 3'd0;
							rdres_d = shift_w;
							done    = 1'b1;
							phase_d = PH_IDLE;
						end else begin
							bit_d   = bit_d + 3'd1;
							phase_d = PH_RD_LOW;
						end
					end
					default:     phase_d = PH_IDLE;
				endcase
			end
		end

		res_d.drive_low = drive;
		res_d.busy_res  = busy;
		res_d.done_res  = done;
		res_d.presence  = presence_d;
		res_d.read_data = rdres_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= 10'd0;
			bit_q      <= 3'd0;
			shift_q    <= 8'd0;
			presence_q <= 1'b0;
			op_q       <= owbm_pkg::OP_NONE;
			rdres_q    <= 8'd0;
		end else if (accept) begin
			phase_q    <= phase_d;
			count_q    <= count_d;
			bit_q      <= bit_d;
			shift_q    <= shift_d;
			presence_q <= presence_d;
			op_q       <= op_d;
			rdres_q    <= rdres_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	// payload holds while the result waits
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, res_q};

endmodule

// File: sim/tb_top.sv
// Self-checking bench for one_wire_bus_master_core: a directed tick table, then random ticks
// under several timing settings and flow-control patterns, each result checked per tick.
// Depends on owbm_pkg and one_wire_bus_master_core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import owbm_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500000;
	localparam int unsigned HOLD_CYCLES = 64;

	typedef enum logic [3:0] {
		PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC,
		PH_WR_LOW, PH_WR_REL, PH_RD_LOW, PH_RD_WAIT, PH_RD_TAIL
	} bus_phase_e;

	typedef enum {SET_ZERO, SET_FLOOR, SET_SMALL, SET_DEFAULT, SET_CEIL} timing_set_e;
	typedef enum {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_e;

	typedef struct {
		logic [1:0]  op;
		logic [7:0]  wd;
		logic        ln;
		int unsigned reps;
		bit          typed;
		result_t     want;
	} tick_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = REG_RESET_LOW;
	logic [9:0]  cfg_data = '0;

	// bus timing model state
	bus_phase_e  bus_ph = PH_IDLE;
	logic [9:0]  slot_cnt = '0;
	logic [2:0]  bit_pos = '0;
	logic [7:0]  slot_byte = '0;
	logic        presence_seen = 1'b0;
	logic [7:0]  read_byte = '0;
	logic [9:0]  tick_len [8];
	logic [9:0]  def_len [8];

	result_t     pending_results [$];
	tick_row_t   dir_rows [$];
	int unsigned s_idle_pct = 0;
	int unsigned r_stall_pct = 0;
	int unsigned hold_asks = 0;
	int unsigned fail_cnt = 0;
	int unsigned run_cycles = 0;

	one_wire_bus_master_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic result_t next_bus_outputs(input logic [1:0] op, input logic [7:0] wd,
			input logic ln);
		result_t    r;
		logic [9:0] span;
		r = '0;
		if (bus_ph == PH_IDLE && op != OP_NONE) begin
			bit_pos = '0;
			slot_cnt = '0;
			case (op)
				OP_RESET: bus_ph = PH_RST_LOW;
				OP_WRITE: begin
					slot_byte = wd;
					bus_ph = PH_WR_LOW;
				end
				default: begin
					slot_byte = '0;
					bus_ph = PH_RD_LOW;
				end
			endcase
		end
		if (bus_ph != PH_IDLE) begin
			case (bus_ph)
				PH_RST_LOW:  span = tick_len[REG_RESET_LOW];
				PH_RST_WAIT: span = tick_len[REG_PRESENCE_WAIT];
				PH_RST_REC:  span = tick_len[REG_RESET_RECOVER];
				PH_WR_LOW:   span = slot_byte[0] ? tick_len[REG_WR1_LOW] : tick_len[REG_WR0_LOW];
				PH_WR_REL:   span = slot_byte[0] ? tick_len[REG_WR1_RELEASE] : 10'd1;
				PH_RD_WAIT:  span = tick_len[REG_RD_SAMPLE];
				PH_RD_TAIL:  span = tick_len[REG_RD_TAIL];
				default:     span = 10'd1;
			endcase
			r.busy_res = 1'b1;
			r.drive_low = (bus_ph == PH_RST_LOW || bus_ph == PH_WR_LOW || bus_ph == PH_RD_LOW);
			slot_cnt = slot_cnt + 10'd1;
			// a zero length ends the slot on its first tick, same as one
			if (slot_cnt >= span) begin
				slot_cnt = '0;
				case (bus_ph)
					PH_RST_LOW: bus_ph = PH_RST_WAIT;
					PH_RST_WAIT: begin
						presence_seen = ~ln;
						bus_ph = PH_RST_REC;
					end
					PH_RST_REC: begin
						r.done_res = 1'b1;
						bus_ph = PH_IDLE;
					end
					PH_WR_LOW: bus_ph = PH_WR_REL;
					PH_WR_REL: begin
						slot_byte = slot_byte >> 1;
						if (bit_pos == 3'd7) begin
							r.done_res = 1'b1;
							bus_ph = PH_IDLE;
						end else begin
							bus_ph = PH_WR_LOW;
						end
						bit_pos = bit_pos + 3'd1;
					end
					PH_RD_LOW: bus_ph = PH_RD_WAIT;
					PH_RD_WAIT: begin
						slot_byte = {ln, slot_byte[7:1]};
						bus_ph = PH_RD_TAIL;
					end
					PH_RD_TAIL: begin
						if (bit_pos == 3'd7) begin
							read_byte = slot_byte;
							r.done_res = 1'b1;
							bus_ph = PH_IDLE;
						end else begin
							bus_ph = PH_RD_LOW;
						end
						bit_pos = bit_pos + 3'd1;
					end
					default: bus_ph = PH_IDLE;
				endcase
			end
		end
		r.presence = presence_seen;
		r.read_data = read_byte;
		return r;
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [7:0] wd, input logic ln,
			input int unsigned reps, input bit typed, input logic dl, input logic bz,
			input logic dn, input logic pr, input logic [7:0] rd);
		tick_row_t row;
		row.op = op;
		row.wd = wd;
		row.ln = ln;
		row.reps = reps;
		row.typed = typed;
		row.want.drive_low = dl;
		row.want.busy_res = bz;
		row.want.done_res = dn;
		row.want.presence = pr;
		row.want.read_data = rd;
		dir_rows.push_back(row);
	endtask

	task automatic set_pace(input pace_e pace);
		s_idle_pct = (pace == PACE_SEND) ? 77 : (pace == PACE_BOTH) ? 19 : 0;
		r_stall_pct = (pace == PACE_RECV) ? 77 : (pace == PACE_BOTH) ? 19 : 0;
	endtask

	task automatic offer_tick(input logic [1:0] op, input logic [7:0] wd, input logic ln,
			input bit typed, input result_t want);
		result_t calc;
		while ($urandom_range(99) < s_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, ln, wd};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		calc = next_bus_outputs(op, wd, ln);
		pending_results.push_back(typed ? want : calc);
	endtask

	task automatic random_tick();
		logic [1:0] op;
		logic [7:0] wd;
		op = OP_NONE;
		if (bus_ph == PH_IDLE) begin
			if ($urandom_range(99) < 80)
				op = 2'($urandom_range(OP_RESET, OP_READ));
		end else if ($urandom_range(99) < 15) begin
			// the core must drop commands that arrive mid-command
			op = 2'($urandom_range(OP_RESET, OP_READ));
		end
		case ($urandom_range(7))
			0:       wd = 8'h00;
			1:       wd = 8'hFF;
			default: wd = 8'($urandom);
		endcase
		offer_tick(op, wd, 1'($urandom_range(1)), 1'b0, '0);
	endtask

	// run the current command out, then hold until every request has come back
	task automatic settle();
		while (bus_ph != PH_IDLE)
			offer_tick(OP_NONE, 8'($urandom), 1'($urandom_range(1)), 1'b0, '0);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic program_timing(input timing_set_e kind, input int unsigned top);
		logic [9:0] v [8];
		for (int i = 0; i < 8; i++) begin
			case (kind)
				SET_ZERO:    v[i] = '0;
				SET_FLOOR:   v[i] = 10'd1;
				SET_SMALL:   v[i] = 10'($urandom_range(1, top));
				SET_DEFAULT: v[i] = def_len[i];
				default:     v[i] = (i == REG_RESET_LOW || i == REG_RESET_RECOVER) ?
						10'd1023 : 10'd255;
			endcase
		end
		for (int i = 0; i < 8; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= v[i];
			do @(posedge clk); while (!cfg_ready);
			tick_len[i] = (i == REG_RESET_LOW || i == REG_RESET_RECOVER) ?
					v[i] : {2'b00, v[i][7:0]};
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(input timing_set_e kind, input int unsigned top, input pace_e pace,
			input int unsigned ticks);
		program_timing(kind, top);
		set_pace(pace);
		for (int unsigned i = 0; i < ticks; i++) begin
			// stall the output long enough for the core to back up into its input
			if (i == ticks / 2)
				hold_asks <= hold_asks + 1;
			if (i == 3 * ticks / 4) begin
				s_tvalid <= 1'b0;
				do @(posedge clk); while (pending_results.size() != 0);
			end
			random_tick();
		end
		settle();
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_results.size() == 0) begin
			$error("unexpected result %h with no request outstanding", got);
			fail_cnt++;
		end else begin
			want = pending_results.pop_front();
			if (got.drive_low !== want.drive_low) begin
				$error("drive_low: expected %0d, got %0d", want.drive_low, got.drive_low);
				fail_cnt++;
			end
			if (got.busy_res !== want.busy_res) begin
				$error("busy_res: expected %0d, got %0d", want.busy_res, got.busy_res);
				fail_cnt++;
			end
			if (got.done_res !== want.done_res) begin
				$error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
				fail_cnt++;
			end
			if (got.presence !== want.presence) begin
				$error("presence: expected %0d, got %0d", want.presence, got.presence);
				fail_cnt++;
			end
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %0h, got %0h", want.read_data, got.read_data);
				fail_cnt++;
			end
		end
	endtask

	initial begin : result_sink
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				check_result(result_t'(m_tdata[11:0]));
			if (hold_seen != hold_asks) begin
				hold_seen = hold_asks;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= r_stall_pct);
			end
		end
	end

	initial begin : watchdog
		while (run_cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			run_cycles++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		def_len[REG_RESET_LOW] = RESET_LOW_DEF;
		def_len[REG_PRESENCE_WAIT] = PRESENCE_WAIT_DEF;
		def_len[REG_RESET_RECOVER] = RESET_RECOVER_DEF;
		def_len[REG_WR1_LOW] = WR1_LOW_DEF;
		def_len[REG_WR1_RELEASE] = WR1_RELEASE_DEF;
		def_len[REG_WR0_LOW] = WR0_LOW_DEF;
		def_len[REG_RD_SAMPLE] = RD_SAMPLE_DEF;
		def_len[REG_RD_TAIL] = RD_TAIL_DEF;
		tick_len = def_len;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every length zero: each slot lasts one tick
		program_timing(SET_ZERO, 0);
		set_pace(PACE_NONE);
		add_row(OP_NONE,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		add_row(OP_RESET, 8'h00, 1'b1, 1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00);
		// device pulls the line low at the presence sample
		add_row(OP_NONE,  8'hFF, 1'b0, 1,  1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 8'h00);
		add_row(OP_NONE,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 8'h00);
		add_row(OP_RESET, 8'h00, 1'b1, 1,  1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00);
		// no device this time; the two commands right below land while busy
		add_row(OP_WRITE, 8'h55, 1'b1, 1,  1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
		add_row(OP_READ,  8'hAA, 1'b0, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00);
		add_row(OP_WRITE, 8'hFF, 1'b1, 16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		add_row(OP_WRITE, 8'h00, 1'b0, 16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		add_row(OP_READ,  8'h00, 1'b1, 23, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
		add_row(OP_NONE,  8'h00, 1'b1, 1,  1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'hFF);
		add_row(OP_NONE,  8'h00, 1'b0, 1,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
		foreach (dir_rows[r])
			for (int unsigned k = 0; k < dir_rows[r].reps; k++)
				offer_tick(dir_rows[r].op, dir_rows[r].wd, dir_rows[r].ln,
						dir_rows[r].typed, dir_rows[r].want);
		settle();

		run_phase(SET_FLOOR,   1,  PACE_NONE, 80);
		run_phase(SET_SMALL,   4,  PACE_SEND, 100);
		run_phase(SET_SMALL,   6,  PACE_RECV, 100);
		run_phase(SET_SMALL,   3,  PACE_BOTH, 100);
		run_phase(SET_SMALL,   16, PACE_BOTH, 80);
		run_phase(SET_FLOOR,   1,  PACE_RECV, 60);

		repeat (8) @(posedge clk);
		if (fail_cnt == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
